// ===== hdl/ssrst_pkg.sv =====
// ============================================================================
// ssrst_pkg
// Shared types and constants of the stepped speed ramp and spin turn core.
// ============================================================================
package ssrst_pkg;

    // Field and register widths
    localparam int CRUISE_W   = 10;
    localparam int PULSE_W    = 16;
    localparam int STEPS_W    = 8;
    localparam int INC_W      = 4;
    localparam int KIND_W     = 3;
    localparam int DRIVE_W    = 11;
    localparam int STEP_W     = 10;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;
    localparam int DIV_CNT_W  = $clog2(PULSE_W);

    // Default speed register width
    localparam int SPEED_WIDTH_DEF = 10;

    // Move constants
    localparam logic [STEPS_W-1:0] TURN_STEPS = STEPS_W'(20);
    localparam int FLOOR_SPEED   = 30;
    localparam int AROUND_DROP   = 10;
    localparam int SETTLE_PASSES = 4;

    // Configuration reset values
    localparam logic [CRUISE_W-1:0] CRUISE_RST  = CRUISE_W'(300);
    localparam logic [PULSE_W-1:0]  SECTION_RST = PULSE_W'(1000);
    localparam logic [PULSE_W-1:0]  TURN_RST    = PULSE_W'(1000);

    // Register indexes on the configuration port
    localparam logic [1:0] REG_CRUISE  = 2'd0;
    localparam logic [1:0] REG_SECTION = 2'd1;
    localparam logic [1:0] REG_TURN    = 2'd2;

    // Request types
    localparam logic REQ_MOVE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        MV_ACCEL  = 3'd0,
        MV_DECEL  = 3'd1,
        MV_SPIN_L = 3'd2,
        MV_SPIN_R = 3'd3,
        MV_AROUND = 3'd4
    } move_kind_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_RISE = 2'd1,
        PH_FALL = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_DIV    = 2'd1,
        S_SETTLE = 2'd2,
        S_EMIT   = 2'd3
    } ctrl_state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic start_move;
        logic start_tick;
        logic div_take;
        logic settle;
        logic out_load;
    } ctrl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic in_is_tick;
        logic in_kind_ok;
        logic div_done;
        logic out_free;
    } dp_status_t;

endpackage

// ===== hdl/ssrst_div.sv =====
// ============================================================================
// ssrst_div
// Two-lane restoring divider: one quotient bit per lane per cycle, both lanes
// sharing one 8-bit divisor.
// ============================================================================
module ssrst_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ssrst_pkg::PULSE_W-1:0] dividend_a,
    input  logic [ssrst_pkg::PULSE_W-1:0] dividend_b,
    input  logic [ssrst_pkg::STEPS_W-1:0] divisor,
    output logic                          done,
    output logic [ssrst_pkg::PULSE_W-1:0] quo_a,
    output logic [ssrst_pkg::PULSE_W-1:0] quo_b
);
    import ssrst_pkg::*;

    localparam int LANE_W = STEPS_W + PULSE_W;

    logic                 run_reg, run_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [PULSE_W-1:0]   num_a_reg, num_a_next;
    logic [PULSE_W-1:0]   num_b_reg, num_b_next;
    logic [STEPS_W-1:0]   rem_a_reg, rem_a_next;
    logic [STEPS_W-1:0]   rem_b_reg, rem_b_next;
    logic [STEPS_W-1:0]   dvs_reg, dvs_next;
    logic [LANE_W-1:0]    lane_a, lane_b;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    function automatic logic [LANE_W-1:0] div_step(
        input logic [STEPS_W-1:0] rem,
        input logic [PULSE_W-1:0] num,
        input logic [STEPS_W-1:0] dvs
    );
        logic [STEPS_W:0]   trial;
        logic               fits;
        logic [STEPS_W-1:0] rem_new;
        trial   = {rem, num[PULSE_W-1]};
        fits    = trial >= {1'b0, dvs};
        rem_new = fits ? STEPS_W'(trial - {1'b0, dvs}) : trial[STEPS_W-1:0];
        return {rem_new, num[PULSE_W-2:0], fits};
    endfunction

    assign lane_a = div_step(rem_a_reg, num_a_reg, dvs_reg);
    assign lane_b = div_step(rem_b_reg, num_b_reg, dvs_reg);

    // Iteration control and lane update
    always_comb
    begin
        run_next   = run_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        num_a_next = num_a_reg;
        num_b_next = num_b_reg;
        rem_a_next = rem_a_reg;
        rem_b_next = rem_b_reg;
        dvs_next   = dvs_reg;
        if (start)
        begin
            run_next   = 1'b1;
            cnt_next   = DIV_CNT_W'(PULSE_W - 1);
            num_a_next = dividend_a;
            num_b_next = dividend_b;
            rem_a_next = '0;
            rem_b_next = '0;
            dvs_next   = divisor;
        end
        else if (run_reg)
        begin
            {rem_a_next, num_a_next} = lane_a;
            {rem_b_next, num_b_next} = lane_b;
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_a_reg <= num_a_next;
        num_b_reg <= num_b_next;
        rem_a_reg <= rem_a_next;
        rem_b_reg <= rem_b_next;
        dvs_reg   <= dvs_next;
    end

    assign done  = done_reg;
    assign quo_a = num_a_reg;
    assign quo_b = num_b_reg;

endmodule

// ===== hdl/ssrst_ctrl.sv =====
// ============================================================================
// ssrst_ctrl
// Sequencing state machine: accepts one word, runs the divider for a move
// command, resolves the speed, then hands the result to the output register.
// ============================================================================
module ssrst_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  ssrst_pkg::dp_status_t  status,
    output ssrst_pkg::ctrl_cmd_t   cmd
);
    import ssrst_pkg::*;

    ctrl_state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (status.in_is_tick)
                    begin
                        cmd.start_tick = 1'b1;
                        state_next     = S_SETTLE;
                    end
                    else if (status.in_kind_ok)
                    begin
                        cmd.start_move = 1'b1;
                        state_next     = S_DIV;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_DIV:
            begin
                if (status.div_done)
                begin
                    cmd.div_take = 1'b1;
                    state_next   = S_SETTLE;
                end
            end
            S_SETTLE:
            begin
                cmd.settle = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/ssrst_dp.sv =====
// ============================================================================
// ssrst_dp
// Datapath: move state, wheel pulse counters, speed resolution, the shared
// divider and the output register.
// ============================================================================
module ssrst_dp #(
    parameter int SPEED_WIDTH = ssrst_pkg::SPEED_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  ssrst_pkg::ctrl_cmd_t                 cmd,
    output ssrst_pkg::dp_status_t                status,
    input  logic                                 req_type,
    input  logic [ssrst_pkg::KIND_W-1:0]         move_kind,
    input  logic [ssrst_pkg::STEPS_W-1:0]        ramp_steps,
    input  logic [ssrst_pkg::INC_W-1:0]          left_increment,
    input  logic [ssrst_pkg::INC_W-1:0]          right_increment,
    input  logic [ssrst_pkg::CRUISE_W-1:0]       cruise_speed,
    input  logic [ssrst_pkg::PULSE_W-1:0]        section_pulses,
    input  logic [ssrst_pkg::PULSE_W-1:0]        turn_pulses,
    input  logic                                 out_stall,
    output logic                                 out_valid,
    output logic signed [ssrst_pkg::DRIVE_W-1:0] left_drive,
    output logic signed [ssrst_pkg::DRIVE_W-1:0] right_drive,
    output logic                                 busy_res,
    output logic                                 move_done
);
    import ssrst_pkg::*;

    // Signed width that holds a speed plus a step, or a cruise minus a step
    localparam int CW = ((SPEED_WIDTH > CRUISE_W) ? SPEED_WIDTH : CRUISE_W) + 2;

    move_kind_t             active_move_reg, active_move_next;
    phase_t                 phase_reg, phase_next;
    logic                   spins_reg, spins_next;
    logic [SPEED_WIDTH-1:0] speed_reg, speed_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [PULSE_W-1:0]     thr_reg, thr_next;
    logic [PULSE_W-1:0]     left_count_reg, left_count_next;
    logic [PULSE_W-1:0]     right_count_reg, right_count_next;
    logic                   fire_reg, fire_next;
    logic                   done_reg, done_next;
    logic signed [CW-1:0]   cand_reg, cand_next;

    logic                   out_valid_reg, out_valid_next;
    logic signed [DRIVE_W-1:0] left_drive_reg, right_drive_reg;
    logic                   busy_out_reg, done_out_reg;

    // Divider hookup
    logic                   straight_in;
    logic                   low_cruise;
    logic [STEPS_W-1:0]     steps_sel;
    logic [PULSE_W-1:0]     pulses_sel;
    logic [PULSE_W-1:0]     div_b_in;
    logic                   div_done;
    logic [PULSE_W-1:0]     quo_a, quo_b;

    // Tick evaluation
    logic [PULSE_W:0]       sum_l, sum_r, watched;
    logic                   tick_fire;
    logic signed [CW-1:0]   cur_s, step_s, cand_tick;

    // Speed resolution
    logic                   straight_mv;
    logic signed [CW-1:0]   cruise_s, half_s, floor_s, lim_spin, peak_s;
    phase_t                 ph_s;
    logic                   sp_s, fin_s, res_s;
    logic signed [CW-1:0]   c_s;

    // Output formatting
    logic [SPEED_WIDTH+DRIVE_W-1:0] speed_wide;
    logic [DRIVE_W-1:0]     s11, neg11;

    // Decode of the word on the input port
    assign status.in_is_tick = req_type == REQ_TICK;
    assign status.in_kind_ok = move_kind <= KIND_W'(MV_AROUND);
    assign status.div_done   = div_done;
    assign status.out_free   = !out_valid_reg || !out_stall;

    // Divider operands for a new move
    assign straight_in = move_kind == KIND_W'(MV_ACCEL) || move_kind == KIND_W'(MV_DECEL);
    assign low_cruise  = cruise_speed <= CRUISE_W'(FLOOR_SPEED);
    assign steps_sel   = straight_in ? ((ramp_steps == '0) ? STEPS_W'(1) : ramp_steps)
                                     : TURN_STEPS;
    assign pulses_sel  = straight_in ? section_pulses : turn_pulses;
    assign div_b_in    = low_cruise ? '0
                                    : PULSE_W'(cruise_speed - CRUISE_W'(FLOOR_SPEED));

    ssrst_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (cmd.start_move),
        .dividend_a (pulses_sel),
        .dividend_b (div_b_in),
        .divisor    (steps_sel),
        .done       (div_done),
        .quo_a      (quo_a),
        .quo_b      (quo_b)
    );

    // Encoder tick: pulse sums, threshold check and the next candidate speed
    always_comb
    begin
        sum_l     = (PULSE_W + 1)'(left_count_reg) + (PULSE_W + 1)'(left_increment);
        sum_r     = (PULSE_W + 1)'(right_count_reg) + (PULSE_W + 1)'(right_increment);
        watched   = (active_move_reg == MV_SPIN_L) ? sum_r : sum_l;
        tick_fire = (phase_reg != PH_IDLE) && (watched > (PULSE_W + 1)'(thr_reg));
        cur_s     = signed'(CW'(speed_reg));
        step_s    = signed'(CW'(step_reg));
        cand_tick = (phase_reg == PH_RISE) ? cur_s + step_s : cur_s - step_s;
    end

    // Speed resolution: walks rise and fall phase changes until a speed holds
    always_comb
    begin
        straight_mv = active_move_reg == MV_ACCEL || active_move_reg == MV_DECEL;
        cruise_s    = signed'(CW'(cruise_speed));
        half_s      = signed'(CW'(cruise_speed >> 1));
        floor_s     = signed'(CW'(FLOOR_SPEED));
        lim_spin    = half_s - signed'(CW'(step_reg));
        peak_s      = (active_move_reg == MV_AROUND) ? half_s - signed'(CW'(AROUND_DROP))
                                                     : half_s;
        ph_s  = phase_reg;
        sp_s  = spins_reg;
        c_s   = cand_reg;
        fin_s = 1'b0;
        res_s = 1'b0;
        for (int i = 0; i < SETTLE_PASSES; i++)
        begin
            if (!res_s)
            begin
                case (ph_s)
                    PH_RISE:
                    begin
                        if (c_s < (straight_mv ? cruise_s : lim_spin))
                        begin
                            res_s = 1'b1;
                        end
                        else if (straight_mv)
                        begin
                            fin_s = 1'b1;
                            res_s = 1'b1;
                        end
                        else
                        begin
                            ph_s = PH_FALL;
                            c_s  = peak_s;
                        end
                    end
                    PH_FALL:
                    begin
                        if (c_s > floor_s)
                        begin
                            res_s = 1'b1;
                        end
                        else if (sp_s)
                        begin
                            // Second half of a spin around starts over
                            sp_s = 1'b0;
                            ph_s = PH_RISE;
                            c_s  = floor_s;
                        end
                        else
                        begin
                            fin_s = 1'b1;
                            res_s = 1'b1;
                        end
                    end
                    default:
                    begin
                        fin_s = 1'b1;
                        res_s = 1'b1;
                    end
                endcase
            end
        end
    end

    // Move state update
    always_comb
    begin
        active_move_next = active_move_reg;
        phase_next       = phase_reg;
        spins_next       = spins_reg;
        speed_next       = speed_reg;
        step_next        = step_reg;
        thr_next         = thr_reg;
        left_count_next  = left_count_reg;
        right_count_next = right_count_reg;
        fire_next        = fire_reg;
        done_next        = done_reg;
        cand_next        = cand_reg;

        if (cmd.accept)
        begin
            done_next = 1'b0;
        end

        if (cmd.start_move)
        begin
            active_move_next = move_kind_t'(move_kind);
            left_count_next  = '0;
            right_count_next = '0;
            speed_next       = '0;
            spins_next       = move_kind == KIND_W'(MV_AROUND);
            fire_next        = 1'b1;
        end

        if (cmd.start_tick)
        begin
            fire_next = tick_fire;
            cand_next = cand_tick;
            if (tick_fire)
            begin
                left_count_next  = '0;
                right_count_next = '0;
            end
            else
            begin
                left_count_next  = sum_l[PULSE_W] ? '1 : sum_l[PULSE_W-1:0];
                right_count_next = sum_r[PULSE_W] ? '1 : sum_r[PULSE_W-1:0];
            end
        end

        // Quotients in: step size, threshold and the starting speed
        if (cmd.div_take)
        begin
            thr_next = quo_a;
            if (low_cruise)
            begin
                step_next  = STEP_W'(1);
                phase_next = PH_IDLE;
            end
            else
            begin
                step_next  = (quo_b == '0) ? STEP_W'(1) : quo_b[STEP_W-1:0];
                phase_next = (active_move_reg == MV_DECEL) ? PH_FALL : PH_RISE;
            end
            cand_next = (active_move_reg == MV_DECEL) ? cruise_s : floor_s;
        end

        if (cmd.settle && fire_reg)
        begin
            done_next = fin_s;
            if (fin_s)
            begin
                phase_next = PH_IDLE;
                spins_next = 1'b0;
                if (active_move_reg == MV_AROUND)
                begin
                    speed_next = '0;
                end
            end
            else
            begin
                phase_next = ph_s;
                spins_next = sp_s;
                speed_next = c_s[SPEED_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_move_reg <= MV_ACCEL;
            phase_reg       <= PH_IDLE;
            spins_reg       <= 1'b0;
            speed_reg       <= '0;
            step_reg        <= '0;
            thr_reg         <= '0;
            left_count_reg  <= '0;
            right_count_reg <= '0;
            fire_reg        <= 1'b0;
            done_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            active_move_reg <= active_move_next;
            phase_reg       <= phase_next;
            spins_reg       <= spins_next;
            speed_reg       <= speed_next;
            step_reg        <= step_next;
            thr_reg         <= thr_next;
            left_count_reg  <= left_count_next;
            right_count_reg <= right_count_next;
            fire_reg        <= fire_next;
            done_reg        <= done_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg <= cand_next;
    end

    // Wheel drive formatting: one side negated for spins
    always_comb
    begin
        speed_wide = (SPEED_WIDTH + DRIVE_W)'(speed_reg);
        s11        = speed_wide[DRIVE_W-1:0];
        neg11      = DRIVE_W'(~s11 + DRIVE_W'(1));
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            left_drive_reg  <= signed'((active_move_reg == MV_SPIN_L) ? neg11 : s11);
            right_drive_reg <= signed'((active_move_reg == MV_SPIN_R ||
                                        active_move_reg == MV_AROUND) ? neg11 : s11);
            busy_out_reg    <= phase_reg != PH_IDLE;
            done_out_reg    <= done_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign left_drive  = left_drive_reg;
    assign right_drive = right_drive_reg;
    assign busy_res    = busy_out_reg;
    assign move_done   = done_out_reg;

endmodule

// ===== hdl/stepped_speed_ramp_and_spin_turn_core.sv =====
// ============================================================================
// stepped_speed_ramp_and_spin_turn_core
// Stepped speed ramp and spin turn generator: top level with register block.
// ============================================================================
// A move command word passes through acceptance, then a two-lane restoring
// divider that produces one quotient bit per cycle for the step size and the
// pulse threshold, then taking the quotients, speed resolution and the load
// of the output register. An encoder tick word passes through acceptance,
// speed resolution and the output load; a command word with an unknown move
// kind goes from acceptance straight to the output load. A full, stalled
// output register holds back the load for as long as it stays full when the
// result is ready to load. One word is processed at a time; the output
// register holds a finished word while the next one is accepted. No clearing
// pass follows reset. Drives are signed wheel speeds; a spin left negates the
// left wheel, a spin right or spin around negates the right wheel.
// ============================================================================
module stepped_speed_ramp_and_spin_turn_core #(
    parameter int SPEED_WIDTH = ssrst_pkg::SPEED_WIDTH_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // Input channel
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic                                    req_type,
    input  logic [ssrst_pkg::KIND_W-1:0]            move_kind,
    input  logic [ssrst_pkg::STEPS_W-1:0]           ramp_steps,
    input  logic [ssrst_pkg::INC_W-1:0]             left_increment,
    input  logic [ssrst_pkg::INC_W-1:0]             right_increment,
    // Output channel
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [ssrst_pkg::DRIVE_W-1:0]    left_drive,
    output logic signed [ssrst_pkg::DRIVE_W-1:0]    right_drive,
    output logic                                    busy_res,
    output logic                                    move_done,
    // Configuration port
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [ssrst_pkg::APB_ADDR_W-1:0]        paddr,
    input  logic [ssrst_pkg::APB_DATA_W-1:0]        pwdata,
    output logic [ssrst_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                    pready
);
    import ssrst_pkg::*;

    logic [CRUISE_W-1:0] cruise_reg, cruise_next;
    logic [PULSE_W-1:0]  section_reg, section_next;
    logic [PULSE_W-1:0]  turn_reg, turn_next;
    logic                cfg_write;
    logic [1:0]          reg_idx;
    ctrl_cmd_t           cmd;
    dp_status_t          status;

    // Configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_idx   = paddr[3:2];

    always_comb
    begin
        cruise_next  = cruise_reg;
        section_next = section_reg;
        turn_next    = turn_reg;
        if (cfg_write)
        begin
            case (reg_idx)
                REG_CRUISE:  cruise_next  = pwdata[CRUISE_W-1:0];
                REG_SECTION: section_next = pwdata[PULSE_W-1:0];
                REG_TURN:    turn_next    = pwdata[PULSE_W-1:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cruise_reg  <= CRUISE_RST;
            section_reg <= SECTION_RST;
            turn_reg    <= TURN_RST;
        end
        else
        begin
            cruise_reg  <= cruise_next;
            section_reg <= section_next;
            turn_reg    <= turn_next;
        end
    end

    // Register read back
    always_comb
    begin
        case (reg_idx)
            REG_CRUISE:  prdata = APB_DATA_W'(cruise_reg);
            REG_SECTION: prdata = APB_DATA_W'(section_reg);
            REG_TURN:    prdata = APB_DATA_W'(turn_reg);
            default:     prdata = '0;
        endcase
    end

    ssrst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    ssrst_dp #(
        .SPEED_WIDTH (SPEED_WIDTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .req_type        (req_type),
        .move_kind       (move_kind),
        .ramp_steps      (ramp_steps),
        .left_increment  (left_increment),
        .right_increment (right_increment),
        .cruise_speed    (cruise_reg),
        .section_pulses  (section_reg),
        .turn_pulses     (turn_reg),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .left_drive      (left_drive),
        .right_drive     (right_drive),
        .busy_res        (busy_res),
        .move_done       (move_done)
    );

endmodule

// ===== hdl/ssrst_chk.sv =====
// ============================================================================
// ssrst_chk
// Port-level checks of the stepped speed ramp and spin turn core.
// ============================================================================
module ssrst_chk (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_stall,
    input logic                                 out_valid,
    input logic                                 out_stall,
    input logic signed [ssrst_pkg::DRIVE_W-1:0] left_drive,
    input logic signed [ssrst_pkg::DRIVE_W-1:0] right_drive,
    input logic                                 busy_res,
    input logic                                 move_done
);
    import ssrst_pkg::*;

    logic [DRIVE_W-1:0] drive_sum;

    assign drive_sum = DRIVE_W'(left_drive + right_drive);

    // A stalled result word stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result word dropped while stalled");

    // A stalled result word keeps its drives.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(left_drive) && $stable(right_drive))
        else $error("result drives changed while stalled");

    // Only one word is in work at a time.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted twice in a row");

    // A finished move is no longer busy.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && move_done |-> !busy_res)
        else $error("finished move still reports busy");

    // Both wheels run at the same magnitude.
    a_drive_mirror: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (left_drive == right_drive) || (drive_sum == '0))
        else $error("wheel drives differ in magnitude");

endmodule

bind stepped_speed_ramp_and_spin_turn_core ssrst_chk u_ssrst_chk (.*);
